@@ rtl/radix_digit_emitter_macros.svh @@
// Assertion macros for the radix digit emitter checker.
// Used by rde_checker.sv; expects clk and rst_n in the including scope.
`ifndef RADIX_DIGIT_EMITTER_MACROS_SVH
`define RADIX_DIGIT_EMITTER_MACROS_SVH

// Clocked property, off while reset is asserted.
`define RDE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("radix_digit_emitter: property failed");

// Clocked property that also holds across reset.
`define RDE_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("radix_digit_emitter: reset property failed");

`endif

@@ rtl/rde_pkg.sv @@
// Shared constants and types for the radix digit emitter.
// No dependencies.
`default_nettype none

package rde_pkg;

  localparam int MAX_SYMBOLS_DEF = 16;
  localparam int VALUE_BITS_DEF  = 32;

  localparam int SYM_SLOTS  = 16;
  localparam int SYM_IDX_W  = 4;
  localparam int BASE_W     = 5;
  localparam int ADDR_W     = 5;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [BASE_W-1:0] MIN_BASE = 5'd2;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_BASE_SIZE    = 2'd0;
  localparam reg_idx_t REG_SYMBOLS_LOW  = 2'd1;
  localparam reg_idx_t REG_SYMBOLS_HIGH = 2'd2;

  localparam logic [BASE_W-1:0]     BASE_RST    = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SYM_LOW_RST  = 64'd3978425819141910832;
  localparam logic [CFG_DATA_W-1:0] SYM_HIGH_RST = 64'd14649;

  typedef struct packed {
    logic [BASE_W-1:0]               base;
    logic [SYM_SLOTS-1:0][7:0]       symbols;
    logic                            ok;
  } cfg_t;

endpackage

`default_nettype wire

@@ rtl/rde_cfg_regs.sv @@
// Configuration registers (APB-style) and registered alphabet check.
// Depends on rde_pkg.
`default_nettype none

module rde_cfg_regs #(
  parameter int MAX_SYMBOLS = rde_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rde_pkg::ADDR_W-1:0]      paddr,
  input  logic [rde_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rde_pkg::CFG_DATA_W-1:0]  prdata,
  output rde_pkg::cfg_t                   cfg
);
  import rde_pkg::*;

  logic [BASE_W-1:0]          base_r;
  logic [CFG_DATA_W-1:0]      sym_low_r;
  logic [CFG_DATA_W-1:0]      sym_high_r;
  logic                       ok_r;
  logic                       ok_nxt;
  logic [SYM_SLOTS-1:0][7:0]  syms;
  reg_idx_t                   idx;
  logic                       wr_en;

  assign idx   = paddr[ADDR_W-1:3];
  assign wr_en = psel && penable && pwrite;
  assign syms  = {sym_high_r, sym_low_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r     <= BASE_RST;
      sym_low_r  <= SYM_LOW_RST;
      sym_high_r <= SYM_HIGH_RST;
      ok_r       <= 1'b0;
    end else begin
      ok_r <= ok_nxt;
      if (wr_en) begin
        unique case (idx)
          REG_BASE_SIZE:    base_r     <= pwdata[BASE_W-1:0];
          REG_SYMBOLS_LOW:  sym_low_r  <= pwdata;
          REG_SYMBOLS_HIGH: sym_high_r <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    ok_nxt = !(base_r < MIN_BASE || base_r > BASE_W'(MAX_SYMBOLS));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (BASE_W'(i) < base_r) begin
        if (syms[i] <= CH_SPACE || syms[i] == CH_DEL ||
            syms[i] == CH_PLUS || syms[i] == CH_MINUS) begin
          ok_nxt = 1'b0;
        end
        for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
          if (BASE_W'(j) < base_r && syms[i] == syms[j]) begin
            ok_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    unique case (idx)
      REG_BASE_SIZE:    prdata = CFG_DATA_W'(base_r);
      REG_SYMBOLS_LOW:  prdata = sym_low_r;
      REG_SYMBOLS_HIGH: prdata = sym_high_r;
      default:          prdata = '0;
    endcase
  end

  assign cfg.base    = base_r;
  assign cfg.symbols = syms;
  assign cfg.ok      = ok_r;

endmodule

`default_nettype wire

@@ rtl/rde_serial_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on rde_pkg.
`default_nettype none

module rde_serial_div #(
  parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_BITS = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [VALUE_BITS-1:0]  dividend,
  input  logic [DIGIT_BITS:0]    radix,
  output logic                   done,
  output logic [VALUE_BITS-1:0]  quotient,
  output logic [DIGIT_BITS-1:0]  remainder
);
  import rde_pkg::*;

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [VALUE_BITS-1:0] quo_r;
  logic [DIGIT_BITS-1:0] rem_r;
  logic [DIGIT_BITS:0]   trial;
  logic [DIGIT_BITS:0]   diff;
  logic                  fits;
  logic [DIGIT_BITS-1:0] rem_nxt;

  assign trial   = {rem_r, quo_r[VALUE_BITS-1]};
  assign fits    = trial >= radix;
  assign diff    = trial - radix;
  assign rem_nxt = fits ? diff[DIGIT_BITS-1:0] : trial[DIGIT_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(VALUE_BITS - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[VALUE_BITS-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ rtl/rde_digit_stack.sv @@
// LIFO of remainder digits: pushed least significant first, popped MSD first.
// Depends on rde_pkg.
`default_nettype none

module rde_digit_stack #(
  parameter int DEPTH      = rde_pkg::VALUE_BITS_DEF,
  parameter int DIGIT_BITS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         clear,
  input  logic                         push,
  input  logic                         pop,
  input  logic [DIGIT_BITS-1:0]        din,
  output logic [DIGIT_BITS-1:0]        top,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  import rde_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  logic [DIGIT_BITS-1:0] mem [DEPTH];
  logic [CNT_W-1:0]      ptr_r;
  logic [CNT_W-1:0]      top_ptr;

  assign top_ptr = ptr_r - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (clear) begin
      ptr_r <= '0;
    end else if (push) begin
      ptr_r <= ptr_r + 1'b1;
    end else if (pop) begin
      ptr_r <= ptr_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[ptr_r[IDX_W-1:0]] <= din;
    end
  end

  assign top   = mem[top_ptr[IDX_W-1:0]];
  assign count = ptr_r;

endmodule

`default_nettype wire

@@ rtl/radix_digit_emitter.sv @@
// radix_digit_emitter: signed integer to text in a configured radix/alphabet.
// Input channel in_valid/in_stall/in_value, one request per number. Output
// channel out_valid/out_stall/out_character/out_last, one request per
// character, out_last on the final one. Registers via the APB-style port:
// base_size at 0x00, symbols_low at 0x08, symbols_high at 0x10.
// A number is worked on alone: in_stall is high from acceptance until its
// last character is loaded into the output register.
// Steps: the alphabet check (registered in rde_cfg_regs), then one bit-serial
// division per digit in rde_serial_div, then emission of each character
// ('-' plus digits) through the output register.
// An invalid alphabet drops the number at the check with no output.
// Reset (rst_n low, synchronous) restores the register defaults and empties
// the pipeline. A stalled receiver freezes character emission; the pending
// character holds in the output register.
// Depends on rde_pkg, rde_cfg_regs, rde_serial_div, rde_digit_stack.
`default_nettype none

module radix_digit_emitter #(
  parameter int MAX_SYMBOLS = rde_pkg::MAX_SYMBOLS_DEF,
  parameter int VALUE_BITS  = rde_pkg::VALUE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [VALUE_BITS-1:0]    in_value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      out_character,
  output logic                            out_last,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rde_pkg::ADDR_W-1:0]      paddr,
  input  logic [rde_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rde_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import rde_pkg::*;

  localparam int DIGIT_BITS = $clog2(MAX_SYMBOLS);
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  cfg_t                  cfg;
  logic [2:0]            state_r, state_nxt;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] mag_r;
  logic [VALUE_BITS-1:0] val_u;
  logic [VALUE_BITS-1:0] mag_in;
  logic                  in_accept;

  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quo;
  logic [DIGIT_BITS-1:0] div_rem;

  logic                  stk_clear, stk_push, stk_pop;
  logic [DIGIT_BITS-1:0] stk_top;
  logic [CNT_W-1:0]      stk_count;

  logic                  out_valid_r, out_valid_nxt;
  logic [7:0]            out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_load;
  logic                  slot_free;

  rde_cfg_regs #(.MAX_SYMBOLS(MAX_SYMBOLS)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  rde_serial_div #(.VALUE_BITS(VALUE_BITS), .DIGIT_BITS(DIGIT_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .radix     (cfg.base[DIGIT_BITS:0]),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  rde_digit_stack #(.DEPTH(VALUE_BITS), .DIGIT_BITS(DIGIT_BITS)) u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (stk_clear),
    .push  (stk_push),
    .pop   (stk_pop),
    .din   (div_rem),
    .top   (stk_top),
    .count (stk_count)
  );

  assign pready    = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign val_u     = in_value;
  assign mag_in    = val_u[VALUE_BITS-1] ? (~val_u + VALUE_BITS'(1)) : val_u;
  assign slot_free = !out_valid_r || !out_stall;
  assign div_dividend = (state_r == S_CHECK) ? mag_r : div_quo;

  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    stk_clear    = 1'b0;
    stk_push     = 1'b0;
    stk_pop      = 1'b0;
    out_load     = 1'b0;
    out_char_nxt = cfg.symbols[SYM_IDX_W'(stk_top)];
    out_last_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (cfg.ok) begin
          div_start = 1'b1;
          stk_clear = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        if (div_done) begin
          stk_push = 1'b1;
          if (div_quo == '0) begin
            state_nxt = neg_r ? S_SIGN : S_EMIT;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_char_nxt = CH_MINUS;
          state_nxt    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_last_nxt = (stk_count == CNT_W'(1));
          stk_pop      = 1'b1;
          if (stk_count == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      neg_r <= val_u[VALUE_BITS-1];
      mag_r <= mag_in;
    end
    if (out_load) begin
      out_char_r <= out_char_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

endmodule

`default_nettype wire

@@ rtl/rde_checker.sv @@
// Port-level checker for radix_digit_emitter, bound to the top level.
// Depends on radix_digit_emitter_macros.svh and rde_pkg.
`default_nettype none
`include "radix_digit_emitter_macros.svh"

module rde_checker #(
  parameter int VALUE_BITS = rde_pkg::VALUE_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic signed [VALUE_BITS-1:0]  in_value,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [7:0]                    out_character,
  input logic                          out_last
);
  import rde_pkg::*;

  `RDE_ASSERT_RST(a_reset_clears, !rst_n |=> !out_valid && !in_stall)
  `RDE_ASSERT(a_busy_after_request, in_valid && !in_stall |=> in_stall)
  `RDE_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid && $stable(in_value))
  `RDE_ASSERT(a_sign_not_last, out_valid && out_character == CH_MINUS |-> !out_last)
  `RDE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_character) && $stable(out_last))

endmodule

bind radix_digit_emitter rde_checker #(.VALUE_BITS(VALUE_BITS)) u_rde_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_value      (in_value),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_character (out_character),
  .out_last      (out_last)
);

`default_nettype wire

@@ tb/radix_digit_emitter_test.sv @@
// Testbench for radix_digit_emitter: signed values in, characters out.
// Predicts the expected text per accepted request in a small class and checks
// each emitted character in order. Depends on rde_pkg and the RTL only.
`default_nettype none

module radix_digit_emitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rde_pkg::*;

  localparam int       VB          = VALUE_BITS_DEF;
  localparam int       HOLD_CYCLES = 1500;
  localparam int       IDLE_LIMIT  = 12000;
  localparam int       SETTLE      = 60;
  localparam reg_idx_t REG_UNUSED  = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_rec_t;

  typedef struct packed {
    logic [BASE_W-1:0]     base;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
  } alphabet_t;

  class char_ledger;
    logic [BASE_W-1:0]     base_size;
    logic [CFG_DATA_W-1:0] sym_low;
    logic [CFG_DATA_W-1:0] sym_high;
    char_rec_t             due_chars[$];
    int                    errors;

    function new();
      base_size = BASE_RST;
      sym_low   = SYM_LOW_RST;
      sym_high  = SYM_HIGH_RST;
      errors    = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BASE_SIZE:    base_size = data[BASE_W-1:0];
        REG_SYMBOLS_LOW:  sym_low = data;
        REG_SYMBOLS_HIGH: sym_high = data;
        default: ;
      endcase
    endfunction

    function logic [7:0] symbol(int idx);
      if (idx < 8) return sym_low[8*idx +: 8];
      return sym_high[8*(idx-8) +: 8];
    endfunction

    function bit alphabet_ok();
      logic [7:0] c;
      if (base_size < MIN_BASE || base_size > MAX_SYMBOLS_DEF) return 1'b0;
      for (int i = 0; i < base_size; i++) begin
        c = symbol(i);
        if (c <= CH_SPACE || c == CH_DEL || c == CH_PLUS || c == CH_MINUS) return 1'b0;
        for (int j = i + 1; j < base_size; j++)
          if (symbol(j) == c) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_value(logic signed [VB-1:0] v);
      logic [VB:0]       mag;
      logic [BASE_W-1:0] digs[$];
      char_rec_t         r;
      if (!alphabet_ok()) return;
      mag = v[VB-1] ? ((33'd1 << VB) - {1'b0, v}) : {1'b0, v};
      do begin
        digs.push_back(BASE_W'(mag % base_size));
        mag = mag / base_size;
      end while (mag != 0);
      if (v[VB-1]) begin
        r.ch   = CH_MINUS;
        r.last = 1'b0;
        due_chars.push_back(r);
      end
      for (int k = digs.size() - 1; k >= 0; k--) begin
        r.ch   = symbol(digs[k]);
        r.last = (k == 0);
        due_chars.push_back(r);
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      char_rec_t r;
      if (due_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got %h last %b", $time, ch, last);
        errors++;
        return;
      end
      r = due_chars.pop_front();
      if (ch !== r.ch) begin
        $display("%0t: character mismatch, expected %h, got %h", $time, r.ch, ch);
        errors++;
      end
      if (last !== r.last) begin
        $display("%0t: last flag mismatch, expected %b, got %b", $time, r.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due_chars.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  wire logic               in_stall;
  logic signed [VB-1:0]    in_value = '0;
  wire logic               out_valid;
  logic                    out_stall = 1'b0;
  wire logic [7:0]         out_character;
  wire logic               out_last;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [ADDR_W-1:0]       paddr = '0;
  logic [CFG_DATA_W-1:0]   pwdata = '0;
  wire logic [CFG_DATA_W-1:0] prdata;
  wire logic               pready;

  char_ledger ledger = new();
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;
  int         idle_cycles = 0;

  radix_digit_emitter u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) ledger.check_char(out_character, out_last);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: stall patterns in stretches, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int span;
    int tick;
    mode = 0;
    span = 0;
    tick = 0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        out_stall <= 1'b0;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(10, 150);
        end
        span--;
        tick++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= $urandom_range(0, 1);
          default: out_stall <= (tick % 7) < 3;
        endcase
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    ledger.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic load_alphabet(input alphabet_t a);
    write_reg(REG_BASE_SIZE, CFG_DATA_W'(a.base));
    write_reg(REG_SYMBOLS_LOW, a.lo);
    write_reg(REG_SYMBOLS_HIGH, a.hi);
  endtask

  task automatic offer_value(input logic signed [VB-1:0] v);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    ledger.note_value(v);
  endtask

  task automatic send_list(input logic signed [VB-1:0] vals[$], input bit dense);
    int burst_left;
    burst_left = $urandom_range(1, 8);
    foreach (vals[i]) begin
      offer_value(vals[i]);
      burst_left--;
      if (!dense && burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        burst_left = $urandom_range(1, 8);
      end
    end
    in_valid <= 1'b0;
  endtask

  task automatic settle();
    while (ledger.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic try_bad(input logic [BASE_W-1:0] base, input logic [CFG_DATA_W-1:0] lo,
                         input logic [CFG_DATA_W-1:0] hi);
    logic signed [VB-1:0] vals[$];
    load_alphabet(alphabet_t'{base, lo, hi});
    vals.push_back(-12345);
    send_list(vals, 1'b0);
    settle();
  endtask

  function automatic alphabet_t random_alphabet();
    alphabet_t  a;
    logic [7:0] pick;
    bit         used[256];
    int         n;
    a.lo = {$urandom, $urandom};
    a.hi = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: n = 2;
      1: n = MAX_SYMBOLS_DEF;
      default: n = $urandom_range(3, MAX_SYMBOLS_DEF - 1);
    endcase
    a.base = BASE_W'(n);
    foreach (used[i]) used[i] = 1'b0;
    for (int i = 0; i < n; i++) begin
      do pick = 8'($urandom_range(33, 255));
      while (pick == CH_DEL || pick == CH_PLUS || pick == CH_MINUS || used[pick]);
      used[pick] = 1'b1;
      if (i < 8) a.lo[8*i +: 8] = pick;
      else a.hi[8*(i-8) +: 8] = pick;
    end
    return a;
  endfunction

  function automatic logic signed [VB-1:0] pick_value();
    int m;
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0: return 0;
          1: return 1;
          2: return -1;
          3: return 32'sh7FFFFFFF;
          default: return 32'sh80000000;
        endcase
      end
      1, 2, 3: begin
        m = $urandom_range(0, 500);
        return $urandom_range(0, 1) ? -m : m;
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    logic signed [VB-1:0] vals[$];
    alphabet_t            a;
    int                   accepted_ok;
    int                   phase;
    int                   n;
    bit                   squeeze;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset alphabet, base 10: the symbol '9' is repeated, so it is rejected
    vals = '{0, 7, -7, 32'sh7FFFFFFF, 32'sh80000000, 1000000000};
    send_list(vals, 1'b0);
    settle();

    // binary, junk in the unused slots
    load_alphabet(alphabet_t'{5'd2, 64'h002D2B7F20313130, 64'h0});
    vals = '{0, 32'sh80000000, 32'sh7FFFFFFF, -5};
    send_list(vals, 1'b0);
    settle();

    write_reg(REG_UNUSED, {$urandom, $urandom});

    // full 16 symbols, high-half bytes and '!' / '~'
    load_alphabet(alphabet_t'{5'd16, SYM_LOW_RST, 64'h42417E21FF803938});
    vals = '{-1, 32'sh80000000, 32'sh7FFFFFFF, 48879};
    send_list(vals, 1'b0);
    settle();

    // rejected alphabets: no characters expected
    try_bad(5'd0, SYM_LOW_RST, SYM_HIGH_RST);
    try_bad(5'd1, SYM_LOW_RST, SYM_HIGH_RST);
    try_bad(5'd17, SYM_LOW_RST, 64'h4645444342413938);
    try_bad(5'd31, SYM_LOW_RST, 64'h4645444342413938);
    try_bad(5'd10, SYM_LOW_RST, 64'h3039);
    try_bad(5'd2, 64'h2030, 64'h0);
    try_bad(5'd2, 64'h7F30, 64'h0);
    try_bad(5'd3, 64'h312B30, 64'h0);
    try_bad(5'd3, 64'h2D3130, 64'h0);
    try_bad(5'd2, 64'h0031, 64'h0);

    accepted_ok = 0;
    phase = 0;
    while (accepted_ok < 60) begin
      if ($urandom_range(0, 4) == 0) begin
        a = alphabet_t'{BASE_W'($urandom), {$urandom, $urandom}, {$urandom, $urandom}};
      end else begin
        a = random_alphabet();
      end
      load_alphabet(a);
      n = $urandom_range(8, 16);
      vals.delete();
      repeat (n) vals.push_back(pick_value());
      squeeze = !hold_req && phase >= 2 && ledger.alphabet_ok();
      if (ledger.alphabet_ok()) accepted_ok += n;
      if (squeeze) hold_req = 1'b1;
      send_list(vals, squeeze);
      settle();
      phase++;
    end

    repeat (200) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+rtl
rtl/rde_pkg.sv
rtl/rde_cfg_regs.sv
rtl/rde_serial_div.sv
rtl/rde_digit_stack.sv
rtl/radix_digit_emitter.sv
rtl/rde_checker.sv
tb/radix_digit_emitter_test.sv
